FILE: rtl/lsee_pkg.sv
// Package: shared types, codes and color helper for the LED strip effect engine.
`default_nettype none

package lsee_pkg;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ADD,
    ST_DECIDE,
    ST_HEAD,
    ST_EMIT
  } state_t;

  localparam logic [2:0] KIND_TICK   = 3'd0;
  localparam logic [2:0] KIND_SOLID  = 3'd1;
  localparam logic [2:0] KIND_FLASH  = 3'd2;
  localparam logic [2:0] KIND_BREATH = 3'd3;
  localparam logic [2:0] KIND_SHIFT  = 3'd4;
  localparam logic [2:0] KIND_BLANK  = 3'd5;

  localparam logic [1:0] MODE_SOLID  = 2'd0;
  localparam logic [1:0] MODE_FLASH  = 2'd1;
  localparam logic [1:0] MODE_BREATH = 2'd2;
  localparam logic [1:0] MODE_SHIFT  = 2'd3;

  localparam logic [2:0] COLOR_BLACK  = 3'd0;
  localparam logic [2:0] COLOR_RED    = 3'd1;
  localparam logic [2:0] COLOR_GREEN  = 3'd2;
  localparam logic [2:0] COLOR_BLUE   = 3'd3;
  localparam logic [2:0] COLOR_YELLOW = 3'd4;

  localparam logic [2:0] REG_BRIGHTNESS         = 3'd0;
  localparam logic [2:0] REG_DEFAULT_BRIGHTNESS = 3'd1;
  localparam logic [2:0] REG_FLASH_INTERVAL     = 3'd2;
  localparam logic [2:0] REG_BREATH_INTERVAL    = 3'd3;
  localparam logic [2:0] REG_SHIFT_INTERVAL     = 3'd4;

  localparam logic [5:0] PHASE_RISE   = 6'd0;
  localparam logic [5:0] PHASE_TOP    = 6'd1;
  localparam logic [5:0] PHASE_FALL   = 6'd2;
  localparam logic [5:0] PHASE_BOTTOM = 6'd3;

  localparam logic [7:0]  RST_BRIGHTNESS      = 8'd100;
  localparam logic [15:0] RST_FLASH_INTERVAL  = 16'd500;
  localparam logic [15:0] RST_BREATH_INTERVAL = 16'd20;
  localparam logic [15:0] RST_SHIFT_INTERVAL  = 16'd50;

  localparam logic [16:0] ELAPSED_MAX  = 17'h1FFFF;
  localparam logic [8:0]  BREATH_STEP  = 9'd3;
  localparam logic [8:0]  BREATH_FLOOR = 9'd3;
  localparam logic [7:0]  BREATH_MIN   = 8'd2;
  localparam logic [8:0]  BG_LEVEL     = 9'd5;
  localparam logic [7:0]  FADE_STEP    = 8'd20;
  localparam int          COMET_LEN    = 5;

  function automatic logic [23:0] grb_of(input logic [2:0] color, input logic [8:0] lvl);
    logic [7:0] v;
    v = lvl[8] ? 8'hFF : lvl[7:0];
    case (color)
      COLOR_RED:    grb_of = {8'h00, v, 8'h00};
      COLOR_GREEN:  grb_of = {v, 8'h00, 8'h00};
      COLOR_BLUE:   grb_of = {8'h00, 8'h00, v};
      COLOR_YELLOW: grb_of = {v, v, 8'h00};
      default:      grb_of = 24'h000000;
    endcase
  endfunction

endpackage

`default_nettype wire

FILE: rtl/led_strip_effect_engine_unit.sv
// Top level: LED strip effect engine with sequencer, shared adder and dot walker.
`default_nettype none

// The engine takes one item at a time and holds in_stall high while busy.
// A command (solid, flash, breath, shift) sets the mode state and emits nothing.
// A tick uses the shared adder for the elapsed update, then for the
// interval decision and, when the dots change, walks DOT_COUNT dots at one
// GRB word per cycle from dot 0 up, last set on the final dot; a shift tick
// first passes through head reduction. Blank and solid ticks go straight to the
// walk. The walk pauses while out_stall holds the output register, and the
// next item is taken as soon as the final dot sits in that register.
module led_strip_effect_engine_unit #(
  parameter int DOT_COUNT = 16
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_write,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [15:0] cfg_data,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [2:0]  kind,
  input  wire logic [2:0]  color,
  input  wire logic [7:0]  period,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [5:0]       dot_index,
  output logic [23:0]      grb_word,
  output logic             last
);

  localparam int         DOT_W    = $clog2(DOT_COUNT);
  localparam logic [DOT_W-1:0] DOT_LAST = DOT_W'(DOT_COUNT - 1);
  localparam logic [6:0] DOT_N7   = 7'(DOT_COUNT);
  localparam logic [5:0] HEAD_MAX = 6'(DOT_COUNT - 1);

  lsee_pkg::state_t state, state_next;

  logic [7:0]  brightness;
  logic [7:0]  default_brightness;
  logic [15:0] flash_interval;
  logic [15:0] breath_interval;
  logic [15:0] shift_interval;

  logic [1:0]  mode, mode_next;
  logic [2:0]  active_color, active_color_next;
  logic [16:0] elapsed, elapsed_next;
  logic [5:0]  phase, phase_next;
  logic [8:0]  level, level_next;

  logic [7:0]  op_period, op_period_next;
  logic [16:0] acc, acc_next;
  logic [2:0]  emit_color, emit_color_next;
  logic [8:0]  emit_level, emit_level_next;
  logic        emit_shift, emit_shift_next;
  logic [DOT_W-1:0] dot, dot_next;
  logic [DOT_W-1:0] dot_dist, dot_dist_next;

  logic        out_valid_next;
  logic [5:0]  dot_index_next;
  logic [23:0] grb_word_next;
  logic        last_next;

  logic [17:0] alu_a, alu_b, alu_res;
  logic        alu_sub;

  logic [7:0]  fade;
  logic [8:0]  shift_level;

  assign alu_res  = alu_sub ? (alu_a - alu_b) : (alu_a + alu_b);
  assign in_stall = (state != lsee_pkg::ST_IDLE);

  always_comb begin
    case (dot_dist)
      DOT_W'(0): fade = 8'd0;
      DOT_W'(1): fade = lsee_pkg::FADE_STEP;
      DOT_W'(2): fade = 8'(2 * lsee_pkg::FADE_STEP);
      DOT_W'(3): fade = 8'(3 * lsee_pkg::FADE_STEP);
      DOT_W'(4): fade = 8'(4 * lsee_pkg::FADE_STEP);
      default:   fade = 8'd0;
    endcase
    if (dot_dist < DOT_W'(lsee_pkg::COMET_LEN)) begin
      shift_level = (brightness >= fade) ? {1'b0, brightness - fade} : level;
    end else begin
      shift_level = (brightness == default_brightness) ? lsee_pkg::BG_LEVEL : 9'd0;
    end
  end

  always_comb begin
    state_next        = state;
    mode_next         = mode;
    active_color_next = active_color;
    elapsed_next      = elapsed;
    phase_next        = phase;
    level_next        = level;
    op_period_next    = op_period;
    acc_next          = acc;
    emit_color_next   = emit_color;
    emit_level_next   = emit_level;
    emit_shift_next   = emit_shift;
    dot_next          = dot;
    dot_dist_next     = dot_dist;
    out_valid_next    = out_valid && out_stall;
    dot_index_next    = dot_index;
    grb_word_next     = grb_word;
    last_next         = last;
    alu_a             = '0;
    alu_b             = '0;
    alu_sub           = 1'b0;

    case (state)
      lsee_pkg::ST_IDLE: begin
        if (in_valid) begin
          op_period_next  = period;
          emit_shift_next = 1'b0;
          dot_next        = '0;
          case (kind)
            lsee_pkg::KIND_TICK: begin
              if (mode == lsee_pkg::MODE_SOLID) begin
                emit_color_next = active_color;
                emit_level_next = {1'b0, brightness};
                state_next      = lsee_pkg::ST_EMIT;
              end else begin
                state_next = lsee_pkg::ST_ADD;
              end
            end
            lsee_pkg::KIND_SOLID: begin
              mode_next         = lsee_pkg::MODE_SOLID;
              active_color_next = color;
            end
            lsee_pkg::KIND_FLASH: begin
              mode_next         = lsee_pkg::MODE_FLASH;
              active_color_next = color;
              elapsed_next      = '0;
            end
            lsee_pkg::KIND_BREATH: begin
              mode_next         = lsee_pkg::MODE_BREATH;
              active_color_next = color;
              elapsed_next      = '0;
              phase_next        = lsee_pkg::PHASE_RISE;
              level_next        = {1'b0, brightness};
            end
            lsee_pkg::KIND_SHIFT: begin
              mode_next         = lsee_pkg::MODE_SHIFT;
              active_color_next = color;
              elapsed_next      = '0;
              phase_next        = '0;
            end
            lsee_pkg::KIND_BLANK: begin
              emit_color_next = lsee_pkg::COLOR_BLACK;
              emit_level_next = '0;
              state_next      = lsee_pkg::ST_EMIT;
            end
            default: ;
          endcase
        end
      end

      lsee_pkg::ST_ADD: begin
        alu_a      = {1'b0, elapsed};
        alu_b      = {10'd0, op_period};
        acc_next   = alu_res[17] ? lsee_pkg::ELAPSED_MAX : alu_res[16:0];
        state_next = lsee_pkg::ST_DECIDE;
      end

      lsee_pkg::ST_DECIDE: begin
        alu_a      = {9'd0, level};
        alu_b      = {9'd0, lsee_pkg::BREATH_STEP};
        alu_sub    = (phase == lsee_pkg::PHASE_FALL);
        state_next = lsee_pkg::ST_IDLE;
        case (mode)
          lsee_pkg::MODE_FLASH: begin
            if (elapsed > {1'b0, flash_interval}) begin
              emit_color_next = (phase != 6'd0) ? active_color : lsee_pkg::COLOR_BLACK;
              emit_level_next = {1'b0, brightness};
              phase_next      = (phase != 6'd0) ? 6'd0 : 6'd1;
              elapsed_next    = {9'd0, op_period};
              state_next      = lsee_pkg::ST_EMIT;
            end else begin
              elapsed_next = acc;
            end
          end
          lsee_pkg::MODE_BREATH: begin
            if (brightness <= lsee_pkg::BREATH_MIN) begin
              level_next      = {1'b0, brightness};
              emit_color_next = lsee_pkg::COLOR_BLACK;
              emit_level_next = '0;
              state_next      = lsee_pkg::ST_EMIT;
            end else begin
              case (phase)
                lsee_pkg::PHASE_RISE, lsee_pkg::PHASE_FALL: begin
                  if ((phase == lsee_pkg::PHASE_RISE) ? (level < {1'b0, brightness})
                                                      : (level > lsee_pkg::BREATH_FLOOR)) begin
                    if (acc > {1'b0, breath_interval}) begin
                      emit_color_next = active_color;
                      emit_level_next = level;
                      level_next      = alu_res[8:0];
                      elapsed_next    = '0;
                      state_next      = lsee_pkg::ST_EMIT;
                    end else begin
                      elapsed_next = acc;
                    end
                  end else begin
                    phase_next   = phase + 6'd1;
                    elapsed_next = '0;
                  end
                end
                lsee_pkg::PHASE_TOP, lsee_pkg::PHASE_BOTTOM: begin
                  if (acc > {1'b0, breath_interval}) begin
                    phase_next   = {4'd0, phase[1:0] + 2'd1};
                    elapsed_next = '0;
                  end else begin
                    elapsed_next = acc;
                  end
                end
                default: ;
              endcase
            end
          end
          lsee_pkg::MODE_SHIFT: begin
            if (acc > {1'b0, shift_interval}) begin
              elapsed_next = '0;
              state_next   = lsee_pkg::ST_HEAD;
            end else begin
              elapsed_next = acc;
            end
          end
          default: ;
        endcase
      end

      lsee_pkg::ST_HEAD: begin
        alu_a   = {12'd0, phase};
        alu_b   = 18'(DOT_COUNT);
        alu_sub = 1'b1;
        if ({1'b0, phase} >= DOT_N7) begin
          phase_next = alu_res[5:0];
        end else begin
          dot_dist_next   = phase[DOT_W-1:0];
          phase_next      = (phase == HEAD_MAX) ? 6'd0 : phase + 6'd1;
          emit_color_next = active_color;
          emit_shift_next = 1'b1;
          state_next      = lsee_pkg::ST_EMIT;
        end
      end

      lsee_pkg::ST_EMIT: begin
        if (!out_valid || !out_stall) begin
          out_valid_next = 1'b1;
          dot_index_next = 6'(dot);
          last_next      = (dot == DOT_LAST);
          if (emit_shift) begin
            level_next    = shift_level;
            grb_word_next = lsee_pkg::grb_of(emit_color, shift_level);
            dot_dist_next = (dot_dist == '0) ? DOT_LAST : dot_dist - DOT_W'(1);
          end else begin
            grb_word_next = lsee_pkg::grb_of(emit_color, emit_level);
          end
          dot_next = dot + DOT_W'(1);
          if (dot == DOT_LAST) begin
            state_next = lsee_pkg::ST_IDLE;
          end
        end
      end

      default: state_next = lsee_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state              <= lsee_pkg::ST_IDLE;
      brightness         <= lsee_pkg::RST_BRIGHTNESS;
      default_brightness <= lsee_pkg::RST_BRIGHTNESS;
      flash_interval     <= lsee_pkg::RST_FLASH_INTERVAL;
      breath_interval    <= lsee_pkg::RST_BREATH_INTERVAL;
      shift_interval     <= lsee_pkg::RST_SHIFT_INTERVAL;
      mode               <= lsee_pkg::MODE_SOLID;
      active_color       <= lsee_pkg::COLOR_BLACK;
      elapsed            <= '0;
      phase              <= '0;
      level              <= '0;
      out_valid          <= 1'b0;
    end else begin
      state        <= state_next;
      mode         <= mode_next;
      active_color <= active_color_next;
      elapsed      <= elapsed_next;
      phase        <= phase_next;
      level        <= level_next;
      out_valid    <= out_valid_next;
      if (cfg_write) begin
        case (cfg_index)
          lsee_pkg::REG_BRIGHTNESS:         brightness         <= cfg_data[7:0];
          lsee_pkg::REG_DEFAULT_BRIGHTNESS: default_brightness <= cfg_data[7:0];
          lsee_pkg::REG_FLASH_INTERVAL:     flash_interval     <= cfg_data;
          lsee_pkg::REG_BREATH_INTERVAL:    breath_interval    <= cfg_data;
          lsee_pkg::REG_SHIFT_INTERVAL:     shift_interval     <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    op_period  <= op_period_next;
    acc        <= acc_next;
    emit_color <= emit_color_next;
    emit_level <= emit_level_next;
    emit_shift <= emit_shift_next;
    dot        <= dot_next;
    dot_dist   <= dot_dist_next;
    dot_index  <= dot_index_next;
    grb_word   <= grb_word_next;
    last       <= last_next;
  end

  a_last_on_final_dot: assert property (@(posedge clk) disable iff (rst)
    out_valid && last |-> dot_index == HEAD_MAX)
    else $error("last flag on a dot other than the final one");

  a_walk_continues: assert property (@(posedge clk) disable iff (rst)
    out_valid && !last |-> state == lsee_pkg::ST_EMIT)
    else $error("walk left before the final dot");

  a_next_dot_follows: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_stall && !last |=> out_valid)
    else $error("gap in the dot walk");

  a_blank_walks: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && kind == lsee_pkg::KIND_BLANK |=> state == lsee_pkg::ST_EMIT)
    else $error("blank item did not start a walk");

endmodule

`default_nettype wire

FILE: sim/led_strip_effect_engine_unit_tb.sv
// Testbench for the LED strip effect engine: predicted dot frames checked against every output transfer.
`timescale 1ns / 1ps

typedef struct packed {
  logic [5:0]  idx;
  logic [23:0] word;
  logic        last;
} dot_t;

class strip_frames #(int DOTS = 16);
  logic [7:0]  brightness;
  logic [7:0]  def_brightness;
  logic [15:0] flash_iv;
  logic [15:0] breath_iv;
  logic [15:0] shift_iv;

  logic [1:0]  mode;
  logic [2:0]  act_color;
  logic [16:0] elapsed;
  logic [5:0]  phase_head;
  logic [8:0]  level;

  dot_t pending_dots[$];
  int   failures;

  function new();
    brightness     = lsee_pkg::RST_BRIGHTNESS;
    def_brightness = lsee_pkg::RST_BRIGHTNESS;
    flash_iv       = lsee_pkg::RST_FLASH_INTERVAL;
    breath_iv      = lsee_pkg::RST_BREATH_INTERVAL;
    shift_iv       = lsee_pkg::RST_SHIFT_INTERVAL;
    mode           = lsee_pkg::MODE_SOLID;
    act_color      = lsee_pkg::COLOR_BLACK;
    elapsed        = '0;
    phase_head     = '0;
    level          = '0;
    failures       = 0;
  endfunction

  function void write_reg(logic [2:0] index, logic [15:0] data);
    case (index)
      lsee_pkg::REG_BRIGHTNESS:         brightness = data[7:0];
      lsee_pkg::REG_DEFAULT_BRIGHTNESS: def_brightness = data[7:0];
      lsee_pkg::REG_FLASH_INTERVAL:     flash_iv = data;
      lsee_pkg::REG_BREATH_INTERVAL:    breath_iv = data;
      lsee_pkg::REG_SHIFT_INTERVAL:     shift_iv = data;
      default: ;
    endcase
  endfunction

  function logic [23:0] color_word(logic [2:0] c, logic [8:0] lvl);
    logic [7:0] v;
    v = (lvl > 9'd255) ? 8'hFF : lvl[7:0];
    case (c)
      lsee_pkg::COLOR_RED:    return {8'h00, v, 8'h00};
      lsee_pkg::COLOR_GREEN:  return {v, 8'h00, 8'h00};
      lsee_pkg::COLOR_BLUE:   return {8'h00, 8'h00, v};
      lsee_pkg::COLOR_YELLOW: return {v, v, 8'h00};
      default:                return 24'h000000;
    endcase
  endfunction

  function void push_dot(int i, logic [23:0] word);
    dot_t d;
    d.idx  = i[5:0];
    d.word = word;
    d.last = (i == DOTS - 1);
    pending_dots.push_back(d);
  endfunction

  function void push_frame(logic [2:0] c, logic [8:0] lvl);
    for (int i = 0; i < DOTS; i++) push_dot(i, color_word(c, lvl));
  endfunction

  function void add_time(logic [7:0] p);
    int unsigned s;
    s = {15'd0, elapsed} + {24'd0, p};
    elapsed = (s > {15'd0, lsee_pkg::ELAPSED_MAX}) ? lsee_pkg::ELAPSED_MAX : s[16:0];
  endfunction

  function void flash_tick(logic [7:0] p);
    if (elapsed > {1'b0, flash_iv}) begin
      if (phase_head != '0) begin
        push_frame(act_color, {1'b0, brightness});
        phase_head = '0;
      end else begin
        push_frame(lsee_pkg::COLOR_BLACK, 9'd0);
        phase_head = 6'd1;
      end
      elapsed = '0;
    end
    add_time(p);
  endfunction

  function void breath_tick(logic [7:0] p);
    if (brightness <= lsee_pkg::BREATH_MIN) begin
      level = {1'b0, brightness};
      push_frame(lsee_pkg::COLOR_BLACK, 9'd0);
      return;
    end
    case (phase_head)
      lsee_pkg::PHASE_RISE: begin
        if (level < {1'b0, brightness}) begin
          add_time(p);
          if (elapsed > {1'b0, breath_iv}) begin
            push_frame(act_color, level);
            level = level + lsee_pkg::BREATH_STEP;
            elapsed = '0;
          end
        end else begin
          phase_head = lsee_pkg::PHASE_TOP;
          elapsed = '0;
        end
      end
      lsee_pkg::PHASE_FALL: begin
        if (level > lsee_pkg::BREATH_FLOOR) begin
          add_time(p);
          if (elapsed > {1'b0, breath_iv}) begin
            push_frame(act_color, level);
            level = level - lsee_pkg::BREATH_STEP;
            elapsed = '0;
          end
        end else begin
          phase_head = lsee_pkg::PHASE_BOTTOM;
          elapsed = '0;
        end
      end
      lsee_pkg::PHASE_TOP, lsee_pkg::PHASE_BOTTOM: begin
        add_time(p);
        if (elapsed > {1'b0, breath_iv}) begin
          phase_head = (phase_head == lsee_pkg::PHASE_BOTTOM) ? lsee_pkg::PHASE_RISE
                                                              : phase_head + 6'd1;
          elapsed = '0;
        end
      end
      default: ;
    endcase
  endfunction

  function void shift_tick(logic [7:0] p);
    int head;
    int d;
    int fade;
    add_time(p);
    if (elapsed <= {1'b0, shift_iv}) return;
    elapsed = '0;
    head = int'(phase_head) % DOTS;
    for (int i = 0; i < DOTS; i++) begin
      d = (head + DOTS - i) % DOTS;
      if (d < lsee_pkg::COMET_LEN) begin
        fade = d * int'(lsee_pkg::FADE_STEP);
        if (int'(brightness) >= fade) level = 9'(int'(brightness) - fade);
      end else begin
        level = (brightness == def_brightness) ? lsee_pkg::BG_LEVEL : 9'd0;
      end
      push_dot(i, color_word(act_color, level));
    end
    phase_head = 6'((head + 1) % DOTS);
  endfunction

  function void take_item(logic [2:0] k, logic [2:0] c, logic [7:0] p);
    case (k)
      lsee_pkg::KIND_TICK: begin
        case (mode)
          lsee_pkg::MODE_SOLID:  push_frame(act_color, {1'b0, brightness});
          lsee_pkg::MODE_FLASH:  flash_tick(p);
          lsee_pkg::MODE_BREATH: breath_tick(p);
          default:               shift_tick(p);
        endcase
      end
      lsee_pkg::KIND_SOLID: begin
        mode = lsee_pkg::MODE_SOLID;
        act_color = c;
      end
      lsee_pkg::KIND_FLASH: begin
        mode = lsee_pkg::MODE_FLASH;
        act_color = c;
        elapsed = '0;
      end
      lsee_pkg::KIND_BREATH: begin
        mode = lsee_pkg::MODE_BREATH;
        act_color = c;
        elapsed = '0;
        phase_head = lsee_pkg::PHASE_RISE;
        level = {1'b0, brightness};
      end
      lsee_pkg::KIND_SHIFT: begin
        mode = lsee_pkg::MODE_SHIFT;
        act_color = c;
        elapsed = '0;
        phase_head = '0;
      end
      lsee_pkg::KIND_BLANK: push_frame(lsee_pkg::COLOR_BLACK, 9'd0);
      default: ;
    endcase
  endfunction

  function void match_dot(logic [5:0] idx, logic [23:0] word, logic last);
    dot_t want;
    if (pending_dots.size() == 0) begin
      failures++;
      if (failures <= 10)
        $display("mismatch: unexpected dot %0d word %h last %b", idx, word, last);
      return;
    end
    want = pending_dots.pop_front();
    if (want.idx !== idx || want.word !== word || want.last !== last) begin
      failures++;
      if (failures <= 10)
        $display("mismatch: expected dot %0d word %h last %b, got dot %0d word %h last %b",
                 want.idx, want.word, want.last, idx, word, last);
    end
  endfunction

  function int pending();
    return pending_dots.size();
  endfunction
endclass

module led_strip_effect_engine_unit_tb;
  localparam int DOTS = 16;
  localparam logic [2:0] KIND_LAST_CODE  = 3'd7;
  localparam logic [2:0] COLOR_LAST_CODE = 3'd7;
  localparam int SETTLE_CYCLES = 20;
  localparam int DRAIN_LIMIT   = 50000;
  localparam int HOLD_CYCLES   = 300;

  logic        clk;
  logic        rst;
  logic        cfg_write;
  logic [2:0]  cfg_index;
  logic [15:0] cfg_data;
  logic        in_valid;
  logic        in_stall;
  logic [2:0]  kind;
  logic [2:0]  color;
  logic [7:0]  period;
  logic        out_valid;
  logic        out_stall;
  logic [5:0]  dot_index;
  logic [23:0] grb_word;
  logic        last;

  strip_frames #(DOTS) frames;

  int burst_left;
  logic hold_req;
  logic hold_done;

  led_strip_effect_engine_unit #(.DOT_COUNT(DOTS)) dut (
    .clk(clk),
    .rst(rst),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .kind(kind),
    .color(color),
    .period(period),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .dot_index(dot_index),
    .grb_word(grb_word),
    .last(last)
  );

  initial clk = 1'b0;
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) frames.match_dot(dot_index, grb_word, last);
  end

  initial begin
    int pat_mode;
    int pat_left;
    int cnt;
    out_stall = 1'b0;
    hold_done = 1'b0;
    pat_mode  = 0;
    pat_left  = 0;
    cnt       = 0;
    forever begin
      @(negedge clk);
      if (hold_req && !hold_done) begin
        out_stall = 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_done = 1'b1;
      end else begin
        if (pat_left == 0) begin
          pat_mode = $urandom_range(0, 3);
          pat_left = $urandom_range(8, 64);
        end
        pat_left--;
        cnt++;
        case (pat_mode)
          0: out_stall = 1'b0;
          1: out_stall = ($urandom_range(0, 99) < 30);
          2: out_stall = cnt[0];
          default: out_stall = ($urandom_range(0, 99) < 75);
        endcase
      end
    end
  end

  task automatic send_item(input logic [2:0] k, input logic [2:0] c, input logic [7:0] p);
    int gap;
    @(negedge clk);
    if (burst_left == 0) begin
      gap = $urandom_range(0, 6);
      burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 10);
      if (gap > 0) begin
        in_valid = 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    kind = k;
    color = c;
    period = p;
    in_valid = 1'b1;
    do @(posedge clk); while (in_stall);
    frames.take_item(k, c, p);
  endtask

  task automatic send_tick();
    send_item(lsee_pkg::KIND_TICK, 3'($urandom_range(0, COLOR_LAST_CODE)),
              8'($urandom_range(0, 255)));
  endtask

  // Wait for every predicted dot, then let an emptyless tick finish.
  task automatic drain();
    int n;
    @(negedge clk);
    in_valid = 1'b0;
    burst_left = 0;
    n = 0;
    while (frames.pending() != 0 && n < DRAIN_LIMIT) begin
      @(posedge clk);
      n++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] index, input logic [15:0] data);
    @(negedge clk);
    cfg_write = 1'b1;
    cfg_index = index;
    cfg_data  = data;
    @(negedge clk);
    cfg_write = 1'b0;
    frames.write_reg(index, data);
  endtask

  task automatic write_all(input logic [7:0] b, input logic [7:0] db, input logic [15:0] fi,
                           input logic [15:0] bi, input logic [15:0] si);
    drain();
    write_reg(lsee_pkg::REG_BRIGHTNESS, {8'h00, b});
    write_reg(lsee_pkg::REG_DEFAULT_BRIGHTNESS, {8'h00, db});
    write_reg(lsee_pkg::REG_FLASH_INTERVAL, fi);
    write_reg(lsee_pkg::REG_BREATH_INTERVAL, bi);
    write_reg(lsee_pkg::REG_SHIFT_INTERVAL, si);
  endtask

  // Mostly a command followed by a run of ticks; now and then noise items.
  task automatic random_runs(input int count);
    int sent;
    int run;
    logic [2:0] k;
    sent = 0;
    while (sent < count) begin
      if ($urandom_range(0, 99) < 10) begin
        k = 3'($urandom_range(lsee_pkg::KIND_BLANK, KIND_LAST_CODE));
        send_item(k, 3'($urandom_range(0, COLOR_LAST_CODE)), 8'($urandom_range(0, 255)));
        if (k == lsee_pkg::KIND_BLANK) sent++;
      end else begin
        send_item(3'($urandom_range(lsee_pkg::KIND_SOLID, lsee_pkg::KIND_SHIFT)),
                  3'($urandom_range(0, COLOR_LAST_CODE)), 8'($urandom_range(0, 255)));
        sent++;
        run = $urandom_range(1, 30);
        repeat (run) send_tick();
        sent += run;
      end
    end
  endtask

  initial begin
    frames     = new();
    rst        = 1'b1;
    cfg_write  = 1'b0;
    cfg_index  = lsee_pkg::REG_BRIGHTNESS;
    cfg_data   = '0;
    in_valid   = 1'b0;
    kind       = lsee_pkg::KIND_TICK;
    color      = lsee_pkg::COLOR_BLACK;
    period     = '0;
    burst_left = 0;
    hold_req   = 1'b0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    send_item(lsee_pkg::KIND_TICK, lsee_pkg::COLOR_BLACK, 8'd0);
    send_item(lsee_pkg::KIND_SOLID, lsee_pkg::COLOR_RED, 8'd0);
    send_item(lsee_pkg::KIND_TICK, lsee_pkg::COLOR_BLACK, 8'd255);
    send_item(lsee_pkg::KIND_BLANK, lsee_pkg::COLOR_YELLOW, 8'd0);
    send_item(KIND_LAST_CODE - 3'd1, lsee_pkg::COLOR_YELLOW, 8'd255);
    send_item(KIND_LAST_CODE, COLOR_LAST_CODE, 8'd0);
    send_item(lsee_pkg::KIND_SOLID, COLOR_LAST_CODE, 8'd0);
    send_item(lsee_pkg::KIND_TICK, lsee_pkg::COLOR_BLACK, 8'd0);
    send_item(lsee_pkg::KIND_FLASH, lsee_pkg::COLOR_YELLOW, 8'd0);
    repeat (5) send_item(lsee_pkg::KIND_TICK, lsee_pkg::COLOR_BLACK, 8'd255);
    send_item(lsee_pkg::KIND_BREATH, lsee_pkg::COLOR_BLUE, 8'd0);
    repeat (3) send_item(lsee_pkg::KIND_TICK, lsee_pkg::COLOR_BLACK, 8'd30);
    send_item(lsee_pkg::KIND_SHIFT, lsee_pkg::COLOR_GREEN, 8'd0);
    send_item(lsee_pkg::KIND_TICK, lsee_pkg::COLOR_BLACK, 8'd255);
    send_item(lsee_pkg::KIND_TICK, lsee_pkg::COLOR_BLACK, 8'd255);
    send_item(lsee_pkg::KIND_TICK, lsee_pkg::COLOR_BLACK, 8'd0);

    // Full brightness: a long breath run over the top and down the fall.
    write_all(8'd255, 8'd255, 16'd0, 16'd0, 16'd0);
    send_item(lsee_pkg::KIND_BREATH, lsee_pkg::COLOR_YELLOW, 8'd0);
    repeat (150) send_tick();
    random_runs(35);

    write_all(8'd0, 8'd0, 16'd1, 16'hFFFF, 16'hFFFF);
    hold_req = 1'b1;
    random_runs(35);

    write_all(8'd2, 8'd7, 16'd300, 16'd3, 16'd7);
    random_runs(35);

    write_all(8'd3, 8'd3, 16'hFFFF, 16'd1, 16'd0);
    random_runs(35);

    write_all(8'd137, 8'd100, 16'd40, 16'd5, 16'd30);
    random_runs(35);

    drain();
    repeat (40) @(posedge clk);
    if (frames.failures == 0 && frames.pending() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin
    #1000000;
    $display("[FAIL] regression broken");
    $finish;
  end
endmodule

FILE: led_strip_effect_engine_unit.f
rtl/lsee_pkg.sv
rtl/led_strip_effect_engine_unit.sv
sim/led_strip_effect_engine_unit_tb.sv
